// ===== rtl/core/hid_key_report_diff_core_assert.svh =====
// assertion macros for the keyboard report change detector
// used by hid_key_report_diff_core; no other dependencies
`ifndef HID_KEY_REPORT_DIFF_CORE_ASSERT_SVH
`define HID_KEY_REPORT_DIFF_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, ignored while reset is asserted
`define HKRD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hkrd assertion failed");
// clocked check that also holds through reset
`define HKRD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hkrd assertion failed");
`else
`define HKRD_ASSERT(label, clk, rst_n, prop)
`define HKRD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/core/hkrd_pkg.sv =====
// shared types, sizes and the usage-to-ascii table for the key report detector
// no dependencies
package hkrd_pkg;

    localparam int KEY_SLOTS  = 6;
    localparam int EVENTS     = 2 * KEY_SLOTS;
    localparam int USAGE_W    = 8;
    localparam int CODE_W     = 7;
    localparam int IN_DATA_W  = KEY_SLOTS * USAGE_W;
    localparam int OUT_DATA_W = 8;

    localparam logic [USAGE_W-1:0] USAGE_NONE = 8'h00;
    localparam logic [CODE_W-1:0]  CODE_NONE  = 7'h00;

    typedef logic [KEY_SLOTS-1:0][USAGE_W-1:0] slot_vec_t;

    // press events at [KEY_SLOTS-1:0], release events above, each in slot order
    typedef struct packed {
        logic [EVENTS-1:0][CODE_W-1:0] code;
        logic [EVENTS-1:0]             valid;
    } ev_set_t;

    function automatic logic [CODE_W-1:0] map_usage(input logic [USAGE_W-1:0] u);
        logic [CODE_W-1:0] c;
        c = CODE_NONE;
        case (u) inside
            [8'h04:8'h1D]: c = CODE_W'(u + 8'h5D);   // letters a-z
            [8'h1E:8'h26]: c = CODE_W'(u + 8'h13);   // digits 1-9
            8'h27: c = 7'h30;
            8'h28: c = 7'h0A;
            8'h29: c = 7'h1B;                        // escape
            8'h2A: c = 7'h08;
            8'h2B: c = 7'h09;
            8'h2C: c = 7'h20;
            8'h2D: c = 7'h2D;
            8'h2E: c = 7'h3D;
            8'h2F: c = 7'h5B;
            8'h30: c = 7'h5D;
            8'h31: c = 7'h5C;
            8'h33: c = 7'h3B;
            8'h34: c = 7'h27;
            8'h35: c = 7'h60;
            8'h36: c = 7'h2C;
            8'h37: c = 7'h2E;
            8'h38: c = 7'h2F;
            8'h39: c = 7'h39;                        // caps lock
            default: c = CODE_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/hkrd_event_gen.sv =====
// compares one report with the previous one and builds the full event set
// depends on hkrd_pkg
module hkrd_event_gen
    import hkrd_pkg::*;
(
    input  slot_vec_t cur_keys,
    input  slot_vec_t old_keys,
    output ev_set_t   events
);

    logic [KEY_SLOTS-1:0] cur_in_old;
    logic [KEY_SLOTS-1:0] old_in_cur;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] cur_code;
    logic [KEY_SLOTS-1:0][CODE_W-1:0] old_code;

    always_comb
    begin
        cur_in_old = '0;
        old_in_cur = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (cur_keys[i] == old_keys[j])
                begin
                    cur_in_old[i] = 1'b1;
                end
                if (old_keys[i] == cur_keys[j])
                begin
                    old_in_cur[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            cur_code[i] = map_usage(cur_keys[i]);
            old_code[i] = map_usage(old_keys[i]);
            events.code[i]             = cur_code[i];
            events.code[KEY_SLOTS + i] = old_code[i];
            // unmapped usages are still compared but never reported
            events.valid[i] = (cur_keys[i] != USAGE_NONE) && !cur_in_old[i]
                              && (cur_code[i] != CODE_NONE);
            events.valid[KEY_SLOTS + i] = (old_keys[i] != USAGE_NONE) && !old_in_cur[i]
                                          && (old_code[i] != CODE_NONE);
        end
    end

endmodule

// ===== rtl/core/hid_key_report_diff_core.sv =====
// Keyboard boot report change detector: turns successive reports into key events.
// Input: s_tvalid/s_tready/s_tdata, one transfer per report carrying the six key
// usage slots, slot 0 in the low byte. Output: m_tvalid/m_tready/m_tdata holds
// the ascii key code, m_tuser is 1 for a press and 0 for a release, m_tlast marks
// the final event of a report. Presses come first in new slot order, then
// releases in old slot order. A report that changes nothing gives no transfer.
// Each report passes the input register, then the event queue, then the output
// register. The queue sends one event per cycle while the receiver accepts, from
// a single 12-entry pending mask, so twelve events is the worst case. The next
// report is taken while earlier events drain.
// Reset clears the stored previous report to all-empty and drops pending events.
// When the receiver stalls, the output register holds, the event queue holds,
// and once the input register is also full s_tready goes low.
// depends on hkrd_pkg, hkrd_event_gen, hid_key_report_diff_core_assert.svh
`include "hid_key_report_diff_core_assert.svh"

module hid_key_report_diff_core
    import hkrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key_slot_0 .. key_slot_5, 8 bits each
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // key_code [6:0], zero [7]
    output logic                  m_tuser,   // pressed
    output logic                  m_tlast
);

    logic      a_valid_reg, a_valid_next;
    slot_vec_t cur_reg;
    slot_vec_t old_reg;
    ev_set_t   gen_events;
    ev_set_t   ev_reg;
    logic [EVENTS-1:0] mask_next;
    logic [EVENTS-1:0] pick;
    logic [EVENTS-1:0] rest;
    logic [CODE_W-1:0] pick_code;
    logic      pick_press;
    logic      ev_busy;
    logic      out_load;
    logic      b_free;
    logic      a_adv;
    logic      s_accept;
    logic      out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic      out_press_reg;
    logic      out_last_reg;

    hkrd_event_gen u_event_gen (
        .cur_keys (cur_reg),
        .old_keys (old_reg),
        .events   (gen_events)
    );

    // lowest pending event goes out first
    assign pick       = ev_reg.valid & (~ev_reg.valid + EVENTS'(1));
    assign rest       = ev_reg.valid & ~pick;
    assign pick_press = |pick[KEY_SLOTS-1:0];
    assign ev_busy    = |ev_reg.valid;

    always_comb
    begin
        pick_code = CODE_NONE;
        for (int k = 0; k < EVENTS; k++)
        begin
            if (pick[k])
            begin
                pick_code = pick_code | ev_reg.code[k];
            end
        end
    end

    assign out_load = ev_busy && (!out_valid_reg || m_tready);
    assign b_free   = !ev_busy || (out_load && (rest == '0));
    assign a_adv    = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || a_adv;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (s_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end

        mask_next = ev_reg.valid;
        if (a_adv)
        begin
            mask_next = gen_events.valid;
        end
        else if (out_load)
        begin
            mask_next = rest;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            cur_reg       <= '0;
            old_reg       <= '0;
            ev_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            ev_reg.valid  <= mask_next;
            out_valid_reg <= out_valid_next;
            if (a_adv)
            begin
                ev_reg.code <= gen_events.code;
            end
            // the report in cur_reg becomes the previous one on each transfer
            if (s_accept)
            begin
                cur_reg <= s_tdata;
                old_reg <= cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_code_reg  <= pick_code;
            out_press_reg <= pick_press;
            out_last_reg  <= b_free;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - CODE_W){1'b0}}, out_code_reg};
    assign m_tuser  = out_press_reg;
    assign m_tlast  = out_last_reg;

    `HKRD_ASSERT(a_code_nonzero, clk, rst_n, m_tvalid |-> (m_tdata[CODE_W-1:0] != CODE_NONE))
    `HKRD_ASSERT(a_mask_hold, clk, rst_n, (ev_busy && !out_load) |=> $stable(ev_reg.valid))
    `HKRD_ASSERT_ALWAYS(a_stall_cause, clk, (!s_tready) |-> (a_valid_reg && ev_busy))

endmodule

// ===== tb/tb.sv =====
// testbench for hid_key_report_diff_core: keyboard reports in, key press/release events out
// checks every event against a built-in predictor of the report change detector
// depends on hkrd_pkg and the rtl of hid_key_report_diff_core
`timescale 1ns / 1ps

module tb;
    import hkrd_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              pressed;
        logic              last;
    } key_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // key_slot_0 .. key_slot_5, 8 bits each
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // key_code [6:0], zero [7]
    logic                  m_tuser;        // pressed
    logic                  m_tlast;

    slot_vec_t  held_keys = '0;            // slots of the last accepted report
    key_event_t expected_events[$];
    bit         steady_flow = 1'b0;        // no random idling on either side while set
    int         rx_hold = 0;               // receiver hold-off, counted down per cycle
    int         mismatch_count = 0;
    int         report_count = 0;
    int         press_count = 0;
    int         release_count = 0;

    hid_key_report_diff_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CODE_W-1:0] ascii_of_usage(input logic [USAGE_W-1:0] usage);
        logic [CODE_W-1:0] code;
        code = 7'h00;
        if (usage >= 8'h04 && usage <= 8'h1d)
            code = CODE_W'(8'h61 + (usage - 8'h04));
        else if (usage >= 8'h1e && usage <= 8'h26)
            code = CODE_W'(8'h31 + (usage - 8'h1e));
        else
        begin
            case (usage)
                8'h27: code = 7'h30;
                8'h28: code = 7'h0a;
                8'h29: code = 7'h1b;
                8'h2a: code = 7'h08;
                8'h2b: code = 7'h09;
                8'h2c: code = 7'h20;
                8'h2d: code = 7'h2d;
                8'h2e: code = 7'h3d;
                8'h2f: code = 7'h5b;
                8'h30: code = 7'h5d;
                8'h31: code = 7'h5c;
                8'h33: code = 7'h3b;
                8'h34: code = 7'h27;
                8'h35: code = 7'h60;
                8'h36: code = 7'h2c;
                8'h37: code = 7'h2e;
                8'h38: code = 7'h2f;
                8'h39: code = 7'h39;
                default: code = 7'h00;
            endcase
        end
        return code;
    endfunction

    function automatic bit report_has(input slot_vec_t slots, input logic [USAGE_W-1:0] usage);
        for (int k = 0; k < KEY_SLOTS; k++)
            if (slots[k] == usage)
                return 1'b1;
        return 1'b0;
    endfunction

    // presses in new slot order, then releases in old slot order
    function automatic void predict_key_events(input slot_vec_t now_keys);
        key_event_t        batch[$];
        key_event_t        ev;
        logic [CODE_W-1:0] code;
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            if (now_keys[k] != USAGE_NONE && !report_has(held_keys, now_keys[k]))
            begin
                code = ascii_of_usage(now_keys[k]);
                if (code != 7'h00)
                begin
                    ev = '{code: code, pressed: 1'b1, last: 1'b0};
                    batch.push_back(ev);
                    press_count++;
                end
            end
        end
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            if (held_keys[k] != USAGE_NONE && !report_has(now_keys, held_keys[k]))
            begin
                code = ascii_of_usage(held_keys[k]);
                if (code != 7'h00)
                begin
                    ev = '{code: code, pressed: 1'b0, last: 1'b0};
                    batch.push_back(ev);
                    release_count++;
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            expected_events.push_back(batch[k]);
        held_keys = now_keys;
        report_count++;
    endfunction

    function automatic logic [USAGE_W-1:0] random_usage();
        if ($urandom_range(99) < 85)
            return USAGE_W'($urandom_range(8'h39, 8'h04));
        return USAGE_W'($urandom);
    endfunction

    // mostly a plausible typing step from the held keys, sometimes pure noise
    function automatic slot_vec_t next_typing_report();
        slot_vec_t rpt;
        rpt = held_keys;
        if ($urandom_range(99) < 20)
        begin
            for (int k = 0; k < KEY_SLOTS; k++)
                rpt[k] = USAGE_W'($urandom);
            return rpt;
        end
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            if (rpt[k] != USAGE_NONE && $urandom_range(99) < 35)
                rpt[k] = USAGE_NONE;
            else if (rpt[k] == USAGE_NONE && $urandom_range(99) < 40)
                rpt[k] = random_usage();
            else if ($urandom_range(99) < 5)
                rpt[k] = rpt[$urandom_range(KEY_SLOTS - 1)];   // duplicate a usage
        end
        return rpt;
    endfunction

    task automatic send_report(input slot_vec_t slots);
        while (!steady_flow && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= slots;
        do
            @(posedge clk);
        while (!s_tready);
        predict_key_events(slots);
    endtask

    task automatic send_bytes(input logic [7:0] u0, input logic [7:0] u1, input logic [7:0] u2,
                              input logic [7:0] u3, input logic [7:0] u4, input logic [7:0] u5);
        send_report({u5, u4, u3, u2, u1, u0});
    endtask

    task automatic test_press_release_all();
        send_bytes(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_full_swap();
        // six presses and six releases from one report
        send_bytes(8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23);
        send_bytes(8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29);
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_table_edges();
        send_bytes(8'h04, 8'h1d, 8'h1e, 8'h26, 8'h27, 8'h28);
        send_bytes(8'h29, 8'h2a, 8'h2c, 8'h31, 8'h33, 8'h39);
        send_bytes(8'h2b, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h34);
        send_bytes(8'h35, 8'h36, 8'h37, 8'h38, 8'h00, 8'h00);
    endtask

    task automatic test_unmapped_usages();
        // unmapped codes give no event but still count as held
        send_bytes(8'h32, 8'h3a, 8'h03, 8'hff, 8'h80, 8'h01);
        send_bytes(8'h32, 8'h04, 8'h03, 8'hff, 8'h7f, 8'h00);
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_duplicates();
        send_bytes(8'h05, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00);
        send_bytes(8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);   // no change, no events
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);   // empty repeat
    endtask

    task automatic test_back_to_back(input int count);
        steady_flow = 1'b1;
        repeat (count)
            send_report(next_typing_report());
        steady_flow = 1'b0;
    endtask

    task automatic test_receiver_stall();
        slot_vec_t rpt;
        rx_hold = 300;
        steady_flow = 1'b1;
        for (int k = 0; k < 20; k++)
        begin
            // alternate between two disjoint full sets, twelve events for each report after the first
            for (int s = 0; s < KEY_SLOTS; s++)
                rpt[s] = USAGE_W'((k % 2 == 0) ? 8'h04 + s : 8'h0a + s);
            send_report(rpt);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_typing(input int count);
        repeat (count)
            send_report(next_typing_report());
    endtask

    // receiver readiness
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady_flow || ($urandom_range(99) >= 15);
        end
    end

    // event checker
    initial
    begin
        key_event_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, actual data=%h user=%b last=%b",
                             $realtime, m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tdata !== {1'b0, want.code})
                    begin
                        $display("%0t: key code mismatch, expected %h actual %h",
                                 $realtime, {1'b0, want.code}, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.pressed)
                    begin
                        $display("%0t: pressed flag mismatch, expected %b actual %b",
                                 $realtime, want.pressed, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last flag mismatch, expected %b actual %b",
                                 $realtime, want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d events still expected",
                 $realtime, STALL_LIMIT, expected_events.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        // drive reset low at time zero so the asynchronous reset sees an edge
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_press_release_all();
        test_full_swap();
        test_table_edges();
        test_unmapped_usages();
        test_duplicates();
        test_receiver_stall();
        test_back_to_back(40);
        test_random_typing(255);

        s_tvalid <= 1'b0;
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d reports: %0d press and %0d release events checked",
                 report_count, press_count, release_count);
        $display("including a long receiver stall and a stretch with no idling, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
